FILE: design/ipq_pkg.sv
// package for the indexed priority queue
// constants, operation and status codes shared by the core and the bench
package ipq_pkg;

  localparam int Capacity   = 256;
  localparam int SlotW      = $clog2(Capacity);
  localparam int CountW     = SlotW + 1;
  localparam int KeyW       = 8;
  localparam int PrioW      = 32;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_REM  = 2'd2,
    OP_PRIO = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_ABSENT  = 3'd3,
    ST_PRESENT = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]       operation;
    logic [KeyW-1:0]  key_id;
    logic signed [PrioW-1:0] priority_req;
  } req_t;

  typedef struct packed {
    logic [2:0]              status;
    logic                    is_empty;
    logic [KeyW-1:0]         top_key;
    logic signed [PrioW-1:0] top_priority;
    logic [CountW-1:0]       entry_count;
  } rsp_t;

  // true when a strictly outranks b
  function automatic logic outranks(logic signed [PrioW-1:0] a,
                                    logic signed [PrioW-1:0] b, logic min_mode);
    return min_mode ? (a < b) : (a > b);
  endfunction

endpackage

FILE: design/ipq_if.sv
// valid/ready channel carrying one packed payload
// depends on nothing; payload type passed as a type parameter
interface ipq_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: design/indexed_priority_queue_core.sv
// indexed priority queue: addressable binary heap of keys with signed priorities
// usage: one request channel (operation, key_id, priority_req), one response
// channel (status, is_empty, top_key, top_priority, entry_count), and a one-bit
// order_mode register (0 max on top, 1 min on top).
// a request is taken only while the core is idle; it then runs a sequencer that
// walks one heap level per step, reading the slot arrays one location per
// cycle. a removal first fetches the removed slot and the last slot and moves
// the last entry into the gap; a moved entry then sifts up and, unless newly
// inserted, down. a new request is taken only after the response is accepted.
// after reset the key table is cleared by a sweep over all 256 entries during
// which no request is taken. the user must see that the register is written
// only while no request is in flight; the core itself does not enforce this.
// a write applies to later compares only.
// the response sits in an output register; while the receiver stalls the core
// holds it and accepts no new request.
// depends on ipq_pkg and ipq_if
module indexed_priority_queue_core (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cfg_we_i,
  input  logic     cfg_wdata_i,
  ipq_if.sink      req_i,
  ipq_if.source    rsp_o
);

  localparam int SW = ipq_pkg::SlotW;
  localparam int CW = ipq_pkg::CountW;
  localparam int KW = ipq_pkg::KeyW;
  localparam int PW = ipq_pkg::PrioW;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_LAST, S_UPRD, S_UPCMP, S_PARK,
    S_DNRD, S_DNRD2, S_DNCMP, S_SWAP, S_TOP, S_TOP2, S_RESP
  } state_e;

  // memories
  logic signed [PW-1:0] prio_mem [ipq_pkg::Capacity];
  logic [KW-1:0]        key_mem  [ipq_pkg::Capacity];
  logic [SW:0]          map_mem  [2**KW]; // msb valid, low bits slot

  state_e               state_q;
  logic                 mode_q;
  logic [CW-1:0]        fill_q;
  logic [KW-1:0]        clr_q;
  ipq_pkg::req_t        req_q;
  ipq_pkg::rsp_t        rsp_q;
  logic                 rsp_valid_q;
  logic [2:0]           status_q;
  logic [SW-1:0]        cur_q, oth_q, pick_q, orig_q;
  logic signed [PW-1:0] cur_p_q, oth_p_q, lft_p_q, sav_p_q;
  logic [KW-1:0]        cur_k_q, oth_k_q, sav_k_q;
  logic                 down_q;   // sift phase: 0 up, 1 down
  logic                 dnonly_q; // insert: no down phase
  logic [1:0]           rd_q;

  // single read port per memory, registered data
  logic [SW-1:0]        raddr;
  logic signed [PW-1:0] rprio_q;
  logic [KW-1:0]        rkey_q;
  logic [SW:0]          map_rd_q;

  logic                 mwe;
  logic [KW-1:0]        maddr;
  logic [SW:0]          mdata;
  logic                 swe;
  logic [SW-1:0]        saddr;
  logic signed [PW-1:0] sprio;
  logic [KW-1:0]        skey;

  logic [CW-1:0] left_c;
  assign left_c = {cur_q, 1'b1};

  logic cmp_res;
  assign cmp_res = ipq_pkg::outranks(cur_p_q, oth_p_q, mode_q);

  logic removing;
  assign removing = req_q.operation inside {ipq_pkg::OP_POP, ipq_pkg::OP_REM};

  always_ff @(posedge clk_i) begin
    if (swe) begin
      prio_mem[saddr] <= sprio;
      key_mem[saddr]  <= skey;
    end
    if (mwe) map_mem[maddr] <= mdata;
    rprio_q  <= prio_mem[raddr];
    rkey_q   <= key_mem[raddr];
    map_rd_q <= map_mem[req_q.key_id];
  end

  assign req_i.ready = (state_q == S_IDLE) && !rsp_valid_q;
  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  // write port and read address selection
  always_comb begin
    mwe = 1'b0; maddr = cur_k_q; mdata = {1'b1, cur_q};
    swe = 1'b0; saddr = cur_q; sprio = cur_p_q; skey = cur_k_q;
    raddr = cur_q;
    case (state_q)
      S_CLEAR: begin
        mwe = 1'b1; maddr = clr_q; mdata = '0;
      end
      S_SWAP: begin
        // cur moves to oth slot, oth moves to cur slot
        swe = 1'b1; saddr = cur_q; sprio = oth_p_q; skey = oth_k_q;
        mwe = 1'b1; maddr = oth_k_q; mdata = {1'b1, cur_q};
      end
      S_PARK, S_DNCMP: begin
        // park the moving entry at its current slot
        swe = 1'b1;
        mwe = 1'b1;
      end
      S_LAST: begin
        // removed slot first, then the last slot; the removed key leaves the table
        raddr = (rd_q == 2'd0) ? cur_q : SW'(fill_q - 1'b1);
        if (rd_q == 2'd1) begin
          mwe = 1'b1; maddr = rkey_q; mdata = '0;
        end
      end
      S_UPRD: raddr = SW'((cur_q - 1'b1) >> 1);
      S_DNRD: raddr = left_c[SW-1:0];
      S_DNRD2: raddr = SW'(left_c + 1'b1);
      S_TOP, S_TOP2: raddr = '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      mode_q      <= 1'b0;
      fill_q      <= '0;
      clr_q       <= '0;
      req_q       <= '0;
      rsp_q       <= '0;
      rsp_valid_q <= 1'b0;
      status_q    <= '0;
      cur_q       <= '0;
      oth_q       <= '0;
      pick_q      <= '0;
      orig_q      <= '0;
      cur_p_q     <= '0;
      oth_p_q     <= '0;
      lft_p_q     <= '0;
      sav_p_q     <= '0;
      cur_k_q     <= '0;
      oth_k_q     <= '0;
      sav_k_q     <= '0;
      down_q      <= 1'b0;
      dnonly_q    <= 1'b0;
      rd_q        <= '0;
    end else begin
      if (cfg_we_i) mode_q <= cfg_wdata_i;
      if (rsp_o.valid && rsp_o.ready) rsp_valid_q <= 1'b0;
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == '1) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (req_i.valid && req_i.ready) begin
            req_q   <= req_i.data;
            rd_q    <= '0;
            state_q <= S_DECODE;
          end
        end
        S_DECODE: begin
          // wait for the registered key table read
          if (rd_q == 2'd0) begin
            rd_q <= 2'd1;
          end else begin
            status_q <= ipq_pkg::ST_OK;
            state_q  <= S_TOP;
            rd_q     <= '0;
            case (ipq_pkg::op_e'(req_q.operation))
              ipq_pkg::OP_PUSH, ipq_pkg::OP_PRIO: begin
                if (map_rd_q[SW]) begin
                  if (req_q.operation == ipq_pkg::OP_PUSH) begin
                    status_q <= ipq_pkg::ST_PRESENT;
                  end else begin
                    cur_q <= map_rd_q[SW-1:0]; cur_p_q <= req_q.priority_req;
                    cur_k_q <= req_q.key_id; down_q <= 1'b0; dnonly_q <= 1'b0;
                    state_q <= S_UPRD;
                  end
                end else if (fill_q == CW'(ipq_pkg::Capacity)) begin
                  status_q <= ipq_pkg::ST_FULL;
                end else begin
                  cur_q <= SW'(fill_q); cur_p_q <= req_q.priority_req;
                  cur_k_q <= req_q.key_id; down_q <= 1'b0; dnonly_q <= 1'b1;
                  fill_q <= fill_q + 1'b1;
                  state_q <= S_UPRD;
                end
              end
              ipq_pkg::OP_POP: begin
                if (fill_q == '0) status_q <= ipq_pkg::ST_EMPTY;
                else begin cur_q <= '0; state_q <= S_LAST; end
              end
              default: begin
                if (!map_rd_q[SW]) status_q <= ipq_pkg::ST_ABSENT;
                else begin
                  cur_q <= map_rd_q[SW-1:0]; state_q <= S_LAST;
                end
              end
            endcase
          end
        end
        S_LAST: begin
          // invalidate removed key, fetch last slot
          if (rd_q != 2'd2) begin
            rd_q <= rd_q + 1'b1;
          end else begin
            rd_q   <= '0;
            fill_q <= fill_q - 1'b1;
            orig_q <= cur_q;
            if (CW'(cur_q) == fill_q - 1'b1) begin
              state_q <= S_TOP;
            end else begin
              cur_p_q <= rprio_q; cur_k_q <= rkey_q;
              down_q <= 1'b0; dnonly_q <= 1'b0;
              state_q <= S_UPRD;
            end
          end
        end
        S_UPRD: begin
          if (cur_q == '0) begin
            state_q <= S_PARK;
          end else if (rd_q == 2'd0) begin
            rd_q <= 2'd1;
          end else begin
            rd_q <= '0;
            oth_q <= SW'((cur_q - 1'b1) >> 1);
            oth_p_q <= rprio_q; oth_k_q <= rkey_q;
            state_q <= S_UPCMP;
          end
        end
        S_UPCMP: begin
          if (cmp_res) begin
            pick_q <= oth_q; state_q <= S_SWAP;
            // the first parent moved into the removed slot sifts down later
            if (cur_q == orig_q) begin
              sav_p_q <= oth_p_q; sav_k_q <= oth_k_q;
            end
          end else begin
            state_q <= S_PARK;
          end
        end
        S_PARK: begin
          if (dnonly_q) begin
            state_q <= S_TOP;
          end else begin
            // after a removal that moved up, sift down from the removed slot
            if (removing && cur_q != orig_q) begin
              cur_q <= orig_q; cur_p_q <= sav_p_q; cur_k_q <= sav_k_q;
            end
            down_q <= 1'b1; rd_q <= '0; state_q <= S_DNRD;
          end
        end
        S_DNRD: begin
          if (left_c >= fill_q) begin
            state_q <= S_DNCMP; oth_q <= cur_q; oth_p_q <= cur_p_q;
          end else if (rd_q == 2'd0) begin
            rd_q <= 2'd1;
          end else begin
            rd_q <= '0;
            lft_p_q <= rprio_q;
            oth_q <= left_c[SW-1:0]; oth_p_q <= rprio_q; oth_k_q <= rkey_q;
            if (left_c + 1'b1 < fill_q) state_q <= S_DNRD2;
            else state_q <= S_DNCMP;
          end
        end
        S_DNRD2: begin
          if (rd_q == 2'd0) begin
            rd_q <= 2'd1;
          end else begin
            rd_q <= '0;
            if (!ipq_pkg::outranks(lft_p_q, rprio_q, mode_q)) begin
              oth_q <= SW'(left_c + 1'b1); oth_p_q <= rprio_q; oth_k_q <= rkey_q;
            end
            state_q <= S_DNCMP;
          end
        end
        S_DNCMP: begin
          // child outranks the moving entry: swap down
          if (oth_q != cur_q && ipq_pkg::outranks(oth_p_q, cur_p_q, mode_q)) begin
            pick_q <= oth_q; state_q <= S_SWAP;
          end else begin
            state_q <= S_TOP;
          end
        end
        S_SWAP: begin
          cur_q <= pick_q;
          state_q <= down_q ? S_DNRD : S_UPRD;
          rd_q <= '0;
        end
        S_TOP: state_q <= S_TOP2;
        S_TOP2: begin
          rsp_q.status       <= status_q;
          rsp_q.is_empty     <= (fill_q == '0);
          rsp_q.top_key      <= (fill_q == '0) ? '0 : rkey_q;
          rsp_q.top_priority <= (fill_q == '0) ? '0 : rprio_q;
          rsp_q.entry_count  <= fill_q;
          rsp_valid_q        <= 1'b1;
          state_q            <= S_RESP;
        end
        S_RESP: begin
          if (!rsp_valid_q) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(ipq_pkg::Capacity)) else $error("count overflow");
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.ready |-> !rsp_valid_q) else $error("ready while response pending");
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && !rsp_o.ready |=> rsp_valid_q) else $error("response dropped");

endmodule

FILE: bench/ipq_scoreboard.sv
// heap predictor and response checker for the indexed priority queue bench
// depends on ipq_pkg
class ipq_scoreboard;
  logic signed [ipq_pkg::PrioW-1:0] prio_at[ipq_pkg::Capacity];
  logic [ipq_pkg::KeyW-1:0] key_at[ipq_pkg::Capacity];
  bit key_held[256];
  int slot_of[256];
  int held;
  bit min_mode;
  ipq_pkg::rsp_t pending[$];
  int failures;

  function void clear();
    held = 0;
    min_mode = 0;
    failures = 0;
    foreach (key_held[k]) key_held[k] = 0;
    pending.delete();
  endfunction

  function bit beats(logic signed [ipq_pkg::PrioW-1:0] a,
                     logic signed [ipq_pkg::PrioW-1:0] b);
    return min_mode ? (a < b) : (a > b);
  endfunction

  function void swap_slots(int a, int b);
    logic signed [ipq_pkg::PrioW-1:0] p;
    logic [ipq_pkg::KeyW-1:0] k;
    p = prio_at[a]; k = key_at[a];
    prio_at[a] = prio_at[b]; key_at[a] = key_at[b];
    prio_at[b] = p; key_at[b] = k;
    slot_of[key_at[a]] = a;
    slot_of[key_at[b]] = b;
  endfunction

  function int raise(int s);
    int parent;
    while (s > 0) begin
      parent = (s - 1) / 2;
      if (!beats(prio_at[s], prio_at[parent])) break;
      swap_slots(s, parent);
      s = parent;
    end
    return s;
  endfunction

  function void lower(int s);
    int left, pick;
    forever begin
      left = 2 * s + 1;
      if (left >= held) break;
      pick = left;
      if (left + 1 < held && !beats(prio_at[left], prio_at[left + 1])) pick = left + 1;
      if (!beats(prio_at[pick], prio_at[s])) break;
      swap_slots(s, pick);
      s = pick;
    end
  endfunction

  function ipq_pkg::status_e insert(logic [7:0] k, logic signed [31:0] p);
    int s;
    if (held >= ipq_pkg::Capacity) return ipq_pkg::ST_FULL;
    s = held;
    held++;
    prio_at[s] = p; key_at[s] = k;
    key_held[k] = 1; slot_of[k] = s;
    void'(raise(s));
    return ipq_pkg::ST_OK;
  endfunction

  function void drop_slot(int s);
    int last;
    last = held - 1;
    key_held[key_at[s]] = 0;
    if (s != last) begin
      prio_at[s] = prio_at[last]; key_at[s] = key_at[last];
      slot_of[key_at[s]] = s;
    end
    held--;
    if (s < held) begin
      void'(raise(s));
      lower(s);
    end
  endfunction

  function void note_request(ipq_pkg::req_t rq);
    ipq_pkg::rsp_t rs;
    ipq_pkg::status_e st;
    int s;
    st = ipq_pkg::ST_OK;
    case (ipq_pkg::op_e'(rq.operation))
      ipq_pkg::OP_PUSH: begin
        if (key_held[rq.key_id]) st = ipq_pkg::ST_PRESENT;
        else st = insert(rq.key_id, rq.priority_req);
      end
      ipq_pkg::OP_POP: begin
        if (held == 0) st = ipq_pkg::ST_EMPTY;
        else drop_slot(0);
      end
      ipq_pkg::OP_REM: begin
        if (!key_held[rq.key_id]) st = ipq_pkg::ST_ABSENT;
        else drop_slot(slot_of[rq.key_id]);
      end
      default: begin
        if (!key_held[rq.key_id]) st = insert(rq.key_id, rq.priority_req);
        else begin
          s = slot_of[rq.key_id];
          prio_at[s] = rq.priority_req;
          void'(raise(s));
          lower(slot_of[rq.key_id]);
        end
      end
    endcase
    rs.status = st;
    rs.is_empty = (held == 0);
    rs.top_key = held == 0 ? '0 : key_at[0];
    rs.top_priority = held == 0 ? '0 : prio_at[0];
    rs.entry_count = held[ipq_pkg::CountW-1:0];
    pending = {pending, rs};
  endfunction

  function void check_response(ipq_pkg::rsp_t got);
    ipq_pkg::rsp_t want;
    if (pending.size() == 0) begin
      $error("response with nothing expected");
      failures++;
      return;
    end
    want = pending.pop_front();
    if (got.status !== want.status) begin
      $error("status: expected %0d actual %0d", want.status, got.status); failures++;
    end
    if (got.is_empty !== want.is_empty) begin
      $error("is_empty: expected %0d actual %0d", want.is_empty, got.is_empty); failures++;
    end
    if (got.top_key !== want.top_key) begin
      $error("top_key: expected %0d actual %0d", want.top_key, got.top_key); failures++;
    end
    if (got.top_priority !== want.top_priority) begin
      $error("top_priority: expected %0d actual %0d", want.top_priority, got.top_priority);
      failures++;
    end
    if (got.entry_count !== want.entry_count) begin
      $error("entry_count: expected %0d actual %0d", want.entry_count, got.entry_count);
      failures++;
    end
  endfunction
endclass

FILE: bench/indexed_priority_queue_core_test.sv
// top-level bench for indexed_priority_queue_core: random heap traffic against a predictor
// depends on ipq_pkg, ipq_if and ipq_scoreboard
module indexed_priority_queue_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_we_i = 0;
  logic cfg_wdata_i = 0;
  bit quiet_send = 0, quiet_take = 0, hold_off = 0;
  int idle_cycles = 0;

  ipq_if #(.payload_t(ipq_pkg::req_t)) req_ch ();
  ipq_if #(.payload_t(ipq_pkg::rsp_t)) rsp_ch ();

  indexed_priority_queue_core uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .req_i(req_ch.sink), .rsp_o(rsp_ch.source)
  );

  ipq_scoreboard heap_model = new();

  always #5 clk_i = ~clk_i;

  initial begin
    req_ch.valid = 0;
    req_ch.data = '0;
    rsp_ch.ready = 0;
  end

  // sample on rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_ch.valid && req_ch.ready) heap_model.note_request(req_ch.data);
      if (rsp_ch.valid && rsp_ch.ready) heap_model.check_response(rsp_ch.data);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || hold_off)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: random stalls, a long hold-off when asked
  always @(negedge clk_i) begin
    if (hold_off) rsp_ch.ready <= 0;
    else rsp_ch.ready <= quiet_take ? 1'b1 : ($urandom_range(99) >= 11);
  end

  always @(posedge clk_i) begin
    if (idle_cycles > 3000) begin
      $display("indexed_priority_queue_core verification failed");
      $finish;
    end
  end

  task automatic send(ipq_pkg::op_e op, logic [7:0] k, logic signed [31:0] p);
    while (!quiet_send && $urandom_range(99) < 11) begin
      req_ch.valid <= 0;
      @(negedge clk_i);
    end
    req_ch.valid <= 1;
    req_ch.data <= '{operation: op, key_id: k, priority_req: p};
    do @(posedge clk_i); while (!req_ch.ready);
    @(negedge clk_i);
  endtask

  task automatic settle();
    req_ch.valid <= 0;
    while (heap_model.pending.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
  endtask

  task automatic set_order(bit m);
    settle();
    cfg_we_i <= 1; cfg_wdata_i <= m;
    @(negedge clk_i);
    cfg_we_i <= 0;
    heap_model.min_mode = m;
  endtask

  function automatic logic signed [31:0] pick_prio();
    case ($urandom_range(5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed(32'($urandom_range(7))) - 32'sd3;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_run(int n, int key_span);
    ipq_pkg::op_e op;
    int r;
    repeat (n) begin
      r = $urandom_range(99);
      op = r < 35 ? ipq_pkg::OP_PUSH : r < 55 ? ipq_pkg::OP_POP :
           r < 75 ? ipq_pkg::OP_REM : ipq_pkg::OP_PRIO;
      send(op, 8'($urandom_range(key_span)), pick_prio());
    end
  endtask

  initial begin
    heap_model.clear();
    repeat (10) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);
    // directed
    send(ipq_pkg::OP_POP, 8'd0, 0);
    send(ipq_pkg::OP_REM, 8'd5, 0);
    send(ipq_pkg::OP_PUSH, 8'd0, 32'sh7fffffff);
    send(ipq_pkg::OP_PUSH, 8'd255, 32'sh80000000);
    send(ipq_pkg::OP_PUSH, 8'd0, 1);
    send(ipq_pkg::OP_PUSH, 8'd7, 32'sh7fffffff);
    send(ipq_pkg::OP_PUSH, 8'd9, 5);
    send(ipq_pkg::OP_PRIO, 8'd9, 32'sh80000000);
    send(ipq_pkg::OP_PRIO, 8'd100, 32'sh55aa55aa);
    send(ipq_pkg::OP_REM, 8'd0, 0);
    send(ipq_pkg::OP_POP, 8'd0, 0);
    send(ipq_pkg::OP_PRIO, 8'd255, -1);
    set_order(1);
    send(ipq_pkg::OP_PUSH, 8'd170, 32'shaaaa5555);
    send(ipq_pkg::OP_POP, 8'd0, 0);
    send(ipq_pkg::OP_REM, 8'd255, 0);
    send(ipq_pkg::OP_POP, 8'd0, 0);
    send(ipq_pkg::OP_POP, 8'd0, 0);
    send(ipq_pkg::OP_POP, 8'd0, 0);
    // fill to capacity, then push and reprioritise a key already held
    quiet_send = 1;
    for (int k = 0; k < 256; k++) send(ipq_pkg::OP_PUSH, k[7:0], 32'($urandom_range(15)));
    send(ipq_pkg::OP_PUSH, 8'd3, 0);
    send(ipq_pkg::OP_PRIO, 8'd3, 32'sh7fffffff);
    random_run(60, 255);
    // receiver holds off while the sender keeps offering
    fork
      begin
        hold_off = 1;
        repeat (400) @(negedge clk_i);
        hold_off = 0;
      end
      random_run(20, 255);
    join
    quiet_send = 0;
    set_order(0);
    random_run(500, 31);
    quiet_send = 1; quiet_take = 1;
    random_run(200, 63);
    quiet_send = 0; quiet_take = 0;
    set_order(1);
    random_run(500, 15);
    set_order(0);
    random_run(300, 255);
    for (int k = 0; k < 40; k++) send(ipq_pkg::OP_POP, 8'd0, 0);
    settle();
    if (heap_model.failures == 0 && heap_model.pending.size() == 0)
      $display("indexed_priority_queue_core verification clean");
    else
      $display("indexed_priority_queue_core verification failed");
    $finish;
  end
endmodule
